// ----- rtl/vwlp_pkg.sv -----
`default_nettype none

package vwlp_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        CFG_LOW_WARN_FLOOR   = 3'd0,
        CFG_NORMAL_FLOOR     = 3'd1,
        CFG_HIGH_WARN_LEVEL  = 3'd2,
        CFG_CUE_ENABLE_FLOOR = 3'd3,
        CFG_STEADY_TIME_MS   = 3'd4,
        CFG_MAINS_INHIBIT_MS = 3'd5,
        CFG_PLUG_COOLDOWN_MS = 3'd6
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers.
    localparam logic [11:0] RST_LOW_WARN_FLOOR   = 12'd1500;
    localparam logic [11:0] RST_NORMAL_FLOOR     = 12'd2070;
    localparam logic [11:0] RST_HIGH_WARN_LEVEL  = 12'd2530;
    localparam logic [11:0] RST_CUE_ENABLE_FLOOR = 12'd1900;
    localparam logic [15:0] RST_STEADY_TIME_MS   = 16'd2000;
    localparam logic [15:0] RST_MAINS_INHIBIT_MS = 16'd3000;
    localparam logic [15:0] RST_PLUG_COOLDOWN_MS = 16'd5000;

    // Fixed timing of the voltage warnings, in ms.
    localparam logic [31:0] LOW_HOLD_MS     = 32'd1500;
    localparam logic [31:0] HIGH_HOLD_MS    = 32'd1000;
    localparam logic [31:0] VOLT_CUE_GAP_MS = 32'd8000;

    // Load thresholds in mA, and their Q15.16 forms for baseline compares.
    localparam logic [14:0] STEADY_DELTA_MA = 15'd80;
    localparam logic [14:0] ADDED_DELTA_MA  = 15'd150;
    localparam logic [14:0] FIRST_LOAD_MA   = 15'd350;
    localparam logic [30:0] BASE_SPLIT_FX   = 31'(150 << 16);
    localparam logic [30:0] ADDED_STEP_FX   = 31'(450 << 16);

    // Division by 50 is done as a halving and a multiply by ceil(2^35 / 25).
    localparam logic [30:0] RECIP_25   = 31'd1374389535;
    localparam int          RECIP_SHFT = 35;

    typedef struct packed {
        logic [11:0] low_warn_floor;
        logic [11:0] normal_floor;
        logic [11:0] high_warn_level;
        logic [11:0] cue_enable_floor;
        logic [15:0] steady_time_ms;
        logic [15:0] mains_inhibit_ms;
        logic [15:0] plug_cooldown_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [11:0] volt_protect;
        logic [14:0] load_ma;
        logic        mains_ok;
        logic        paused;
        logic        fault_free;
    } t_sample;

endpackage

`default_nettype wire

// ----- rtl/vwlp_volt.sv -----
`default_nettype none

module vwlp_volt (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_commit,
    input  wire vwlp_pkg::t_sample i_smp,
    input  wire vwlp_pkg::t_cfg   i_cfg,
    output logic                  o_cue_low,
    output logic                  o_cue_high
);
    import vwlp_pkg::*;

    logic        r_low_armed, n_low_armed;
    logic [31:0] r_low_since, n_low_since;
    logic        r_high_armed, n_high_armed;
    logic [31:0] r_high_since, n_high_since;
    logic [31:0] r_last_cue, n_last_cue;

    logic        low_warn;
    logic        high_warn;
    logic        gap_ok;
    logic [31:0] low_age;
    logic [31:0] high_age;
    logic [31:0] cue_age;

    always_comb begin
        low_warn  = (i_smp.volt_protect >= i_cfg.low_warn_floor) &&
                    (i_smp.volt_protect < i_cfg.normal_floor);
        high_warn = i_smp.volt_protect >= i_cfg.high_warn_level;

        // A condition starts its timer on the first sample that shows it.
        n_low_armed  = low_warn;
        n_low_since  = !low_warn ? 32'd0 : (r_low_armed ? r_low_since : i_smp.time_ms);
        n_high_armed = high_warn;
        n_high_since = !high_warn ? 32'd0 : (r_high_armed ? r_high_since : i_smp.time_ms);

        low_age  = i_smp.time_ms - n_low_since;
        high_age = i_smp.time_ms - n_high_since;
        cue_age  = i_smp.time_ms - r_last_cue;
        gap_ok   = cue_age >= VOLT_CUE_GAP_MS;

        // The low cue has priority: the high cue is blocked while the low cue
        // fires, so both cannot show in the same sample; either cue restarts the spacing.
        o_cue_low  = n_low_armed && (low_age >= LOW_HOLD_MS) && gap_ok;
        o_cue_high = n_high_armed && (high_age >= HIGH_HOLD_MS) && gap_ok && !o_cue_low;

        n_last_cue = (o_cue_low || o_cue_high) ? i_smp.time_ms : r_last_cue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_armed  <= 1'b0;
            r_low_since  <= 32'd0;
            r_high_armed <= 1'b0;
            r_high_since <= 32'd0;
            r_last_cue   <= 32'd0;
        end else if (i_commit) begin
            r_low_armed  <= n_low_armed;
            r_low_since  <= n_low_since;
            r_high_armed <= n_high_armed;
            r_high_since <= n_high_since;
            r_last_cue   <= n_last_cue;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vwlp_load.sv -----
`default_nettype none

module vwlp_load (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_commit,
    input  wire vwlp_pkg::t_sample i_smp,
    input  wire vwlp_pkg::t_cfg   i_cfg,
    output logic                  o_cue_plug
);
    import vwlp_pkg::*;

    logic [30:0] r_base, n_base;
    logic [14:0] r_prev_load, n_prev_load;
    logic        r_steady_armed, n_steady_armed;
    logic [31:0] r_steady_since, n_steady_since;
    logic        r_mains_armed, n_mains_armed;
    logic [31:0] r_mains_since, n_mains_since;
    logic [31:0] r_last_plug, n_last_plug;

    logic               track_off;
    logic [14:0]        delta;
    logic [30:0]        load_fx;
    logic signed [31:0] diff;
    logic [31:0]        neg_diff;
    logic [30:0]        mag;
    logic [60:0]        prod;
    logic [25:0]        quot;
    logic [30:0]        base_adj;
    logic [30:0]        base_new;
    logic signed [31:0] rise;
    logic               adapt;
    logic               allowed;
    logic               first_load;
    logic               added_load;
    logic               plug;

    always_comb begin
        track_off = !i_smp.mains_ok || (i_smp.volt_protect < i_cfg.cue_enable_floor) ||
                    !i_smp.fault_free;
        load_fx   = {i_smp.load_ma, 16'd0};
        delta     = (i_smp.load_ma >= r_prev_load) ? (i_smp.load_ma - r_prev_load)
                                                   : (r_prev_load - i_smp.load_ma);

        n_mains_armed  = 1'b1;
        n_mains_since  = r_mains_armed ? r_mains_since : i_smp.time_ms;
        n_steady_armed = delta < STEADY_DELTA_MA;
        n_steady_since = !n_steady_armed ? 32'd0
                       : (r_steady_armed ? r_steady_since : i_smp.time_ms);
        adapt = n_steady_armed &&
                ((i_smp.time_ms - n_steady_since) >= {16'd0, i_cfg.steady_time_ms});

        // Baseline step: (load - baseline) / 50, truncated toward zero.
        diff     = $signed({1'b0, load_fx}) - $signed({1'b0, r_base});
        neg_diff = 32'(-diff);
        mag      = diff[31] ? neg_diff[30:0] : diff[30:0];
        prod     = 61'(mag[30:1]) * 61'(RECIP_25);
        quot     = prod[RECIP_SHFT +: 26];
        base_adj = diff[31] ? (r_base - 31'(quot)) : (r_base + 31'(quot));
        base_new = adapt ? base_adj : r_base;

        rise       = $signed({1'b0, load_fx}) - $signed({1'b0, base_new});
        allowed    = (i_smp.time_ms - n_mains_since) >= {16'd0, i_cfg.mains_inhibit_ms};
        first_load = (base_new < BASE_SPLIT_FX) && (i_smp.load_ma >= FIRST_LOAD_MA);
        added_load = (base_new >= BASE_SPLIT_FX) && !rise[31] &&
                     (rise[30:0] >= ADDED_STEP_FX) && (delta < ADDED_DELTA_MA);
        plug = !track_off && allowed && (first_load || added_load) &&
               ((i_smp.time_ms - r_last_plug) >= {16'd0, i_cfg.plug_cooldown_ms});

        n_prev_load = i_smp.load_ma;
        n_base      = base_new;
        n_last_plug = r_last_plug;
        if (track_off) begin
            n_base         = 31'd0;
            n_steady_armed = 1'b0;
            n_steady_since = 32'd0;
            n_mains_armed  = 1'b0;
            n_mains_since  = 32'd0;
        end else if (plug) begin
            // A new load becomes the baseline and the steady run restarts.
            n_base         = load_fx;
            n_last_plug    = i_smp.time_ms;
            n_steady_armed = 1'b0;
            n_steady_since = 32'd0;
        end
        o_cue_plug = plug;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base         <= 31'd0;
            r_prev_load    <= 15'd0;
            r_steady_armed <= 1'b0;
            r_steady_since <= 32'd0;
            r_mains_armed  <= 1'b0;
            r_mains_since  <= 32'd0;
            r_last_plug    <= 32'd0;
        end else if (i_commit) begin
            r_base         <= n_base;
            r_prev_load    <= n_prev_load;
            r_steady_armed <= n_steady_armed;
            r_steady_since <= n_steady_since;
            r_mains_armed  <= n_mains_armed;
            r_mains_since  <= n_mains_since;
            r_last_plug    <= n_last_plug;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/voltage_warning_and_load_plug_cue_unit.sv -----
// Voltage warning and plug cue unit.
// Each input beat is one sample: timestamp, protection voltage, load current
// and the mains, paused and fault-free flags. Each sample yields exactly one
// output beat with three cue flags. A beat moves on a rising edge where its
// valid is high and its stall is low.
// A sample is captured in an input register, evaluated against the timer and
// baseline state, and its cues land in an output register. One sample is
// taken per cycle as long as the output side keeps up. The limit is the
// combinational state update, which holds one 30x31 multiply for the
// baseline step. When the receiver stalls, the output beat holds, the input
// register keeps one more sample, and o_stall rises only when both are full.
// The seven configuration registers are written through i_cfg_we, i_cfg_idx
// and i_cfg_wdata; unknown indexes are ignored. The user must write them
// only while no sample is in flight; the block itself does not enforce this.
// Synchronous reset empties both registers, restores the register defaults
// and clears all timers, flags and the baseline.
`default_nettype none

module voltage_warning_and_load_plug_cue_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Configuration write port.
    input  wire                            i_cfg_we,
    input  wire [vwlp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [vwlp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Sample channel.
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire [31:0]                     i_time_ms,
    input  wire [11:0]                     i_volt_protect,
    input  wire [14:0]                     i_load_ma,
    input  wire                            i_mains_ok,
    input  wire                            i_paused,
    input  wire                            i_fault_free,
    // Cue channel.
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic                           o_cue_volt_low,
    output logic                           o_cue_volt_high,
    output logic                           o_cue_plug
);
    import vwlp_pkg::*;

    t_cfg    r_cfg;
    logic    r_s1_valid, n_s1_valid;
    t_sample r_s1;
    logic    r_out_valid, n_out_valid;
    logic    r_cue_low, r_cue_high, r_cue_plug;

    logic in_take;
    logic s1_fire;
    logic commit;
    logic cue_low_c, cue_high_c, cue_plug_c;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_warn_floor   <= RST_LOW_WARN_FLOOR;
            r_cfg.normal_floor     <= RST_NORMAL_FLOOR;
            r_cfg.high_warn_level  <= RST_HIGH_WARN_LEVEL;
            r_cfg.cue_enable_floor <= RST_CUE_ENABLE_FLOOR;
            r_cfg.steady_time_ms   <= RST_STEADY_TIME_MS;
            r_cfg.mains_inhibit_ms <= RST_MAINS_INHIBIT_MS;
            r_cfg.plug_cooldown_ms <= RST_PLUG_COOLDOWN_MS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LOW_WARN_FLOOR:   r_cfg.low_warn_floor   <= i_cfg_wdata[11:0];
                CFG_NORMAL_FLOOR:     r_cfg.normal_floor     <= i_cfg_wdata[11:0];
                CFG_HIGH_WARN_LEVEL:  r_cfg.high_warn_level  <= i_cfg_wdata[11:0];
                CFG_CUE_ENABLE_FLOOR: r_cfg.cue_enable_floor <= i_cfg_wdata[11:0];
                CFG_STEADY_TIME_MS:   r_cfg.steady_time_ms   <= i_cfg_wdata;
                CFG_MAINS_INHIBIT_MS: r_cfg.mains_inhibit_ms <= i_cfg_wdata;
                CFG_PLUG_COOLDOWN_MS: r_cfg.plug_cooldown_ms <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: the sample in the input register is evaluated when the
    // output register is free or is being emptied in the same cycle.
    always_comb begin
        s1_fire = r_s1_valid && !(r_out_valid && i_stall);
        o_stall = r_s1_valid && r_out_valid && i_stall;
        in_take = i_valid && !o_stall;
        commit  = s1_fire && !r_s1.paused;

        n_s1_valid = in_take ? 1'b1 : (s1_fire ? 1'b0 : r_s1_valid);
        n_out_valid = s1_fire ? 1'b1 : (i_stall ? r_out_valid : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1.time_ms      <= i_time_ms;
            r_s1.volt_protect <= i_volt_protect;
            r_s1.load_ma      <= i_load_ma;
            r_s1.mains_ok     <= i_mains_ok;
            r_s1.paused       <= i_paused;
            r_s1.fault_free   <= i_fault_free;
        end
        // A paused sample reports no cues.
        if (s1_fire) begin
            r_cue_low  <= cue_low_c && !r_s1.paused;
            r_cue_high <= cue_high_c && !r_s1.paused;
            r_cue_plug <= cue_plug_c && !r_s1.paused;
        end
    end

    vwlp_volt u_volt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (commit),
        .i_smp      (r_s1),
        .i_cfg      (r_cfg),
        .o_cue_low  (cue_low_c),
        .o_cue_high (cue_high_c)
    );

    vwlp_load u_load (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (commit),
        .i_smp      (r_s1),
        .i_cfg      (r_cfg),
        .o_cue_plug (cue_plug_c)
    );

    assign o_valid         = r_out_valid;
    assign o_cue_volt_low  = r_cue_low;
    assign o_cue_volt_high = r_cue_high;
    assign o_cue_plug      = r_cue_plug;

`ifndef SYNTHESIS
    // The high cue is blocked while the low cue fires, so both never show together.
    a_one_volt_cue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_cue_volt_low && o_cue_volt_high))
        else $error("both voltage cues in one beat");

    // A paused sample produces an output beat with all cues clear.
    a_paused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1.paused) |=>
        (o_valid && !o_cue_volt_low && !o_cue_volt_high && !o_cue_plug))
        else $error("paused sample produced a cue");

    // A sample waiting in the input register is neither lost nor altered.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1)))
        else $error("waiting sample lost or changed");
`endif

endmodule

`default_nettype wire
